[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority task queue
// Opcodes, result status codes, the entry layout and the per-cell command.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int unsigned PRIO_W   = 16;
	localparam int unsigned PAYLD_W  = 32;
	localparam int unsigned LIMIT_W  = 7;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_DRAIN = 2'd2,
		OP_CLOSE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_CLOSED = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [PAYLD_W-1:0]       payload;
	} entry_t;

	// Broadcast to every cell in the cycle a request is taken
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cell_cmd_t;

endpackage

`default_nettype wire

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry and its occupied bit. On push it keeps its entry, takes the
// new entry or takes its left neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire logic      left_keep,
	input  wire logic      left_valid,
	input  wire entry_t    left_data,
	input  wire logic      right_valid,
	input  wire entry_t    right_data,
	output logic           valid,
	output entry_t         data,
	output logic           keep
);

	logic   valid_q;
	entry_t data_q;

	// Entry stays ahead of a new task of equal or lower priority
	assign keep = valid_q && (data_q.prio >= cmd.ent.prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= left_valid;
		end else if (cmd.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !keep) begin
			data_q <= left_keep ? cmd.ent : left_data;
		end else if (cmd.pop) begin
			data_q <= right_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

`default_nettype wire

[hdl/sorted_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_task_queue: priority queue as a row of sorting cells
// Tasks wait sorted by descending priority; equal priorities leave in order.
//
//   channel   handshake          payload
//   request   start / busy       opcode, task_priority, task_payload
//   result    done (1 cycle)     status, out_priority, out_payload, entry_count
//   config    cfg_we             cfg_wdata (capacity limit)
//
// One request per cycle: all cells compare against the new task in parallel
// and shift together, so busy stays low. The result appears on the cycle
// after the request is taken. Reset empties and opens the queue and sets the
// limit to 64. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_task_queue
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                opcode,
	input  wire logic signed [PRIO_W-1:0]  task_priority,
	input  wire logic [PAYLD_W-1:0]        task_payload,
	output logic                           done,
	output logic [1:0]                     status,
	output logic signed [PRIO_W-1:0]       out_priority,
	output logic [PAYLD_W-1:0]             out_payload,
	output logic [LIMIT_W-1:0]             entry_count,
	input  wire logic                      cfg_we,
	input  wire logic [LIMIT_W-1:0]        cfg_wdata
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [LIMIT_W-1:0] limit_q;
	logic               closed_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               accept;
	opcode_t            op;
	logic [CMP_W-1:0]   cnt_ext;
	logic               full;
	logic               empty;
	cell_cmd_t          cmd;
	status_t            status_d;
	logic [CNT_W-1:0]   cnt_d;

	logic               valid_w [DEPTH];
	entry_t             data_w  [DEPTH];
	logic               keep_w  [DEPTH];

	logic               done_q;
	status_t            status_q;
	entry_t             out_q;
	logic [CNT_W-1:0]   count_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign op      = opcode_t'(opcode);
	assign cnt_ext = CMP_W'(cnt_q);
	assign full    = (cnt_ext >= CMP_W'(limit_q)) || (cnt_ext >= DEPTH_C);
	assign empty   = (cnt_q == '0);

	always_comb begin
		cmd.push    = 1'b0;
		cmd.pop     = 1'b0;
		cmd.ent     = '{prio: task_priority, payload: task_payload};
		status_d    = ST_DONE;
		cnt_d       = cnt_q;
		case (op)
			OP_PUSH: begin
				if (closed_q) begin
					status_d = ST_CLOSED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.push = accept;
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			OP_POP, OP_DRAIN: begin
				if (op == OP_POP && closed_q) begin
					status_d = ST_CLOSED;
				end else if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.pop = accept;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   lk, lv, rv;
		entry_t ld, rd;
		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign lv = 1'b1;
			assign ld = cmd.ent;
		end else begin : g_mid
			assign lk = keep_w[i-1];
			assign lv = valid_w[i-1];
			assign ld = data_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_body
			assign rv = valid_w[i+1];
			assign rd = data_w[i+1];
		end
		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_keep   (lk),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (valid_w[i]),
			.data        (data_w[i]),
			.keep        (keep_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_W'(64);
			closed_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			done_q <= accept;
			if (accept) begin
				cnt_q <= cnt_d;
				if (op == OP_CLOSE) begin
					closed_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			count_q  <= cnt_d;
			out_q    <= cmd.pop ? data_w[0] : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_priority = out_q.prio;
	assign out_payload  = out_q.payload;
	assign entry_count  = LIMIT_W'(count_q);

endmodule

`default_nettype wire
